// ===== hdl/fat_dir_entry_parser_defines.svh =====
// Assertion helpers used by the parser RTL.
`ifndef FAT_DIR_ENTRY_PARSER_DEFINES_SVH
`define FAT_DIR_ENTRY_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fdp_pkg.sv =====
`default_nettype none
package fdp_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LFN,
    ST_TERM,
    ST_SEL,
    ST_NAME,
    ST_OUT
  } state_e;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [7:0] BYTE_KANJI   = 8'h05;
  localparam logic [7:0] ATTR_LONG    = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;
  localparam logic [4:0] ORDER_MAX    = 5'd20;
  localparam logic [3:0] LFN_CHARS    = 4'd13;
  localparam int unsigned IDX_W       = 9;
  localparam logic [IDX_W-1:0] NAME_CAP = 9'd256;

  // UCS-2 character i of a long-name entry
  function automatic logic [15:0] lfn_char(input logic [255:0] e, input logic [3:0] i);
    logic [15:0] c;
    unique case (i)
      4'd0:    c = e[23:8];
      4'd1:    c = e[39:24];
      4'd2:    c = e[55:40];
      4'd3:    c = e[71:56];
      4'd4:    c = e[87:72];
      4'd5:    c = e[127:112];
      4'd6:    c = e[143:128];
      4'd7:    c = e[159:144];
      4'd8:    c = e[175:160];
      4'd9:    c = e[191:176];
      4'd10:   c = e[207:192];
      4'd11:   c = e[239:224];
      4'd12:   c = e[255:240];
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fdp_in_if.sv =====
`default_nettype none
interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] bytes_0_7;
  logic [63:0] bytes_8_15;
  logic [63:0] bytes_16_23;
  logic [63:0] bytes_24_31;
  logic        new_directory;

  modport source (output valid, bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31,
                  new_directory, input ready);
  modport sink (input valid, bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31,
                new_directory, output ready);
endinterface
`default_nettype wire

// ===== hdl/fdp_out_if.sv =====
`default_nettype none
interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  attributes;
  logic [31:0] file_size;
  logic [31:0] start_cluster;
  logic [63:0] name_chunk;
  logic [3:0]  chunk_length;
  logic        last;

  modport source (output valid, kind, attributes, file_size, start_cluster, name_chunk,
                  chunk_length, last, input ready);
  modport sink (input valid, kind, attributes, file_size, start_cluster, name_chunk,
                chunk_length, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/fat_dir_entry_parser.sv =====
// Sequence: an end-of-directory word is offered in the cycle after its entry
//   is accepted; a regular entry passes ST_SEL, then ST_NAME and ST_OUT for
//   each name word; a long-name entry passes ST_LFN per character, then ST_TERM.
// Throughput: one entry at a time; one name byte a cycle, held while in ST_OUT.
// Reset (async, active low) clears the name store valid bits and pending flag
//   at once, so no clearing pass is needed; new_directory does the same.
`default_nettype none
`include "fat_dir_entry_parser_defines.svh"
module fat_dir_entry_parser #(
  parameter int unsigned NAME_LIMIT = 255
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fdp_in_if.sink    in_i,
  fdp_out_if.source out_o
);

  localparam int unsigned DEPTH = NAME_LIMIT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [fdp_pkg::IDX_W-1:0] LIM   = fdp_pkg::IDX_W'(NAME_LIMIT);
  localparam logic [fdp_pkg::IDX_W-1:0] DEPTHV = fdp_pkg::IDX_W'(DEPTH);

  fdp_pkg::state_e st_q, st_d;

  logic [255:0] ent_q;
  logic [fdp_pkg::IDX_W-1:0] base_q, pos_q, pos_d;
  logic [3:0]  i_q, i_d, cnt_q, cnt_d;
  logic        pending_q, pending_d, long_q, long_d;
  logic [63:0] chunk_q, chunk_d;
  logic [7:0]  sn_q [12];
  logic [3:0]  snlen_q;
  logic [7:0]  attr_q;
  logic [31:0] size_q, clus_q;
  logic        kind_q, kind_d, olast_q, olast_d;
  logic [63:0] ochunk_q, ochunk_d;
  logic [3:0]  olen_q, olen_d;

  // Name store and its valid bits
  logic [7:0]     mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]     rdata_q;
  logic           rvalid_q;
  logic           we, re, vclr, clr_all;
  logic [AW-1:0]  waddr, raddr, vaddr;
  logic [7:0]     wdata;

  logic acc;
  assign acc = in_i.valid && in_i.ready;

  // Short name from the incoming entry
  logic [7:0] b [11];
  logic [7:0] sn_d [12];
  logic [3:0] snlen_d, bl, el, n_raw;
  logic       stop, hasext;
  logic [3:0] j;
  always_comb begin
    for (int k = 0; k < 8; k++) b[k] = in_i.bytes_0_7[8*k +: 8];
    for (int k = 0; k < 3; k++) b[8+k] = in_i.bytes_8_15[8*k +: 8];
    if (b[0] == fdp_pkg::BYTE_KANJI) b[0] = fdp_pkg::BYTE_DELETED;
    bl = 4'd8;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!stop && b[k] == fdp_pkg::CHAR_SPACE) begin
        bl = 4'(k);
        stop = 1'b1;
      end
    end
    el = 4'd3;
    stop = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!stop && b[8+k] == fdp_pkg::CHAR_SPACE) begin
        el = 4'(k);
        stop = 1'b1;
      end
    end
    hasext = (b[8] != fdp_pkg::CHAR_SPACE);
    n_raw = hasext ? (bl + 4'd1 + el) : bl;
    for (int k = 0; k < 12; k++) begin
      j = 4'(k) - bl - 4'd1;
      if (4'(k) < bl) sn_d[k] = b[k < 8 ? k : 0];
      else if (4'(k) == bl) sn_d[k] = fdp_pkg::CHAR_DOT;
      else if (j < 4'd3) sn_d[k] = b[8 + int'(j[1:0])];
      else sn_d[k] = 8'h00;
    end
    snlen_d = n_raw;
    stop = 1'b0;
    for (int k = 0; k < 12; k++) begin
      if (!stop && 4'(k) < n_raw && sn_d[k] == 8'h00) begin
        snlen_d = 4'(k);
        stop = 1'b1;
      end
    end
  end

  // Current long-name character and the store address it lands at
  logic [15:0] ch;
  logic [7:0]  chn;
  logic [fdp_pkg::IDX_W-1:0] laddr;
  logic [7:0]  cur;
  logic        endc;
  logic [4:0]  order;
  always_comb begin
    ch    = fdp_pkg::lfn_char(ent_q, i_q);
    chn   = (ch >= 16'h0020 && ch < 16'h007F) ? ch[7:0] : fdp_pkg::CHAR_QMARK;
    laddr = base_q + fdp_pkg::IDX_W'(i_q);
    order = in_i.bytes_0_7[4:0];
    if (long_q) cur = rvalid_q ? rdata_q : 8'h00;
    else if (pos_q < fdp_pkg::IDX_W'(snlen_q)) cur = sn_q[pos_q[3:0]];
    else cur = 8'h00;
    endc = (pos_q == fdp_pkg::NAME_CAP) ||
           (long_q ? (pos_q >= LIM || cur == 8'h00)
                   : (pos_q >= fdp_pkg::IDX_W'(snlen_q)));
  end

  // Sequencer
  always_comb begin
    st_d = st_q; i_d = i_q; cnt_d = cnt_q; pos_d = pos_q;
    pending_d = pending_q; long_d = long_q; chunk_d = chunk_q;
    kind_d = kind_q; olast_d = olast_q; ochunk_d = ochunk_q; olen_d = olen_q;
    we = 1'b0; re = 1'b0; vclr = 1'b0; clr_all = 1'b0;
    waddr = '0; raddr = '0; vaddr = '0; wdata = chn;
    in_i.ready = (st_q == fdp_pkg::ST_IDLE);
    unique case (st_q)
      fdp_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_i.new_directory) begin
            clr_all = 1'b1;
            pending_d = 1'b0;
          end
          re = 1'b1;
          i_d = '0;
          priority if (in_i.bytes_0_7[7:0] == fdp_pkg::BYTE_END) begin
            kind_d = 1'b1; olast_d = 1'b1; ochunk_d = '0; olen_d = '0;
            st_d = fdp_pkg::ST_OUT;
          end else if (in_i.bytes_0_7[7:0] == fdp_pkg::BYTE_DELETED) begin
            pending_d = 1'b0; vclr = 1'b1;
          end else if (in_i.bytes_8_15[31:24] == fdp_pkg::ATTR_LONG) begin
            if (order != 5'd0 && order <= fdp_pkg::ORDER_MAX) begin
              pending_d = 1'b1;
              st_d = fdp_pkg::ST_LFN;
            end
          end else if ((in_i.bytes_8_15[31:24] & fdp_pkg::ATTR_VOLUME) != 8'h00) begin
            pending_d = 1'b0; vclr = 1'b1;
          end else begin
            kind_d = 1'b0;
            st_d = fdp_pkg::ST_SEL;
          end
        end
      end
      fdp_pkg::ST_LFN: begin
        if (ch == 16'h0000 || ch == 16'hFFFF) begin
          st_d = fdp_pkg::ST_TERM;
        end else begin
          if (laddr < LIM) begin
            we = 1'b1;
            waddr = laddr[AW-1:0];
          end
          i_d = i_q + 4'd1;
          if (i_q == fdp_pkg::LFN_CHARS - 4'd1) st_d = fdp_pkg::ST_TERM;
        end
      end
      fdp_pkg::ST_TERM: begin
        if (ent_q[6] && laddr <= LIM) begin
          vclr = 1'b1;
          vaddr = laddr[AW-1:0];
        end
        st_d = fdp_pkg::ST_IDLE;
      end
      fdp_pkg::ST_SEL: begin
        long_d = pending_q && rvalid_q && (rdata_q != 8'h00);
        pending_d = 1'b0;
        vclr = 1'b1;
        pos_d = '0; cnt_d = '0; chunk_d = '0;
        st_d = fdp_pkg::ST_NAME;
      end
      fdp_pkg::ST_NAME: begin
        if (endc) begin
          ochunk_d = chunk_q; olen_d = cnt_q; olast_d = 1'b1;
          st_d = fdp_pkg::ST_OUT;
        end else if (cnt_q == 4'd8) begin
          ochunk_d = chunk_q; olen_d = cnt_q; olast_d = 1'b0;
          chunk_d = '0; cnt_d = '0;
          st_d = fdp_pkg::ST_OUT;
        end else begin
          chunk_d[8*cnt_q[2:0] +: 8] = cur;
          cnt_d = cnt_q + 4'd1;
          pos_d = pos_q + 9'd1;
          re = 1'b1;
          raddr = (pos_d < DEPTHV) ? pos_d[AW-1:0] : '0;
        end
      end
      fdp_pkg::ST_OUT: begin
        if (out_o.ready) st_d = olast_q ? fdp_pkg::ST_IDLE : fdp_pkg::ST_NAME;
      end
      default: st_d = fdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= fdp_pkg::ST_IDLE;
      pending_q <= 1'b0;
      valid_q <= '0;
    end else begin
      st_q <= st_d;
      pending_q <= pending_d;
      if (clr_all) valid_q <= '0;
      else if (vclr) valid_q[vaddr] <= 1'b0;
      if (we) valid_q[waddr] <= 1'b1;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d; cnt_q <= cnt_d; pos_q <= pos_d; long_q <= long_d; chunk_q <= chunk_d;
    kind_q <= kind_d; olast_q <= olast_d; ochunk_q <= ochunk_d; olen_q <= olen_d;
    if (acc) begin
      ent_q   <= {in_i.bytes_24_31, in_i.bytes_16_23, in_i.bytes_8_15, in_i.bytes_0_7};
      base_q  <= fdp_pkg::IDX_W'((fdp_pkg::IDX_W'(order) - 9'd1) * 9'd13);
      sn_q    <= sn_d;
      snlen_q <= snlen_d;
      attr_q  <= in_i.bytes_8_15[31:24];
      size_q  <= in_i.bytes_24_31[63:32];
      clus_q  <= {in_i.bytes_16_23[47:32], in_i.bytes_24_31[31:16]};
    end
  end

  // Name store port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_q  <= mem[raddr];
      rvalid_q <= valid_q[raddr] && !clr_all;
    end
  end

  // Output word
  assign out_o.valid         = (st_q == fdp_pkg::ST_OUT);
  assign out_o.kind          = kind_q;
  assign out_o.attributes    = kind_q ? 8'h00 : attr_q;
  assign out_o.file_size     = kind_q ? 32'h0 : size_q;
  assign out_o.start_cluster = kind_q ? 32'h0 : clus_q;
  assign out_o.name_chunk    = ochunk_q;
  assign out_o.chunk_length  = olen_q;
  assign out_o.last          = olast_q;

  `FDP_ASSERT_IMP(a_eod_empty, out_o.valid && out_o.kind,
                  out_o.last && out_o.chunk_length == 4'd0,
                  "end of directory word not empty")
  `FDP_ASSERT_IMP(a_full_mid, out_o.valid && !out_o.last,
                  out_o.chunk_length == 4'd8, "non-final word not full")
  `FDP_ASSERT_IMP(a_lfn_idx, st_q == fdp_pkg::ST_LFN,
                  i_q < fdp_pkg::LFN_CHARS, "long-name index out of range")
  `FDP_ASSERT_NXT(a_done_idle, out_o.valid && out_o.ready && out_o.last,
                  in_i.ready, "not idle after final word")

endmodule
`default_nettype wire

// ===== bench/fdp_tb_if.sv =====
`timescale 1ns / 100ps
// Channel interfaces are provided by the RTL (fdp_in_if, fdp_out_if).
// This file holds the shared bench types for the entry and result words.
package fdp_tb_pkg;

  typedef struct packed {
    logic [255:0] entry;
    logic         new_dir;
  } entry_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  attributes;
    logic [31:0] file_size;
    logic [31:0] start_cluster;
    logic [63:0] name_chunk;
    logic [3:0]  chunk_length;
    logic        last;
  } record_word_t;

endpackage

// ===== bench/fdp_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels, predicts record words and compares them in order.
module fdp_checker #(
  parameter int unsigned NAME_LIMIT = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  fdp_in_if    in_mon,
  fdp_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  logic [7:0]   name_store [0:NAME_LIMIT];
  logic         name_pending;
  fdp_tb_pkg::record_word_t expected_records[$];

  assign pending_count = expected_records.size();

  // UCS-2 offsets of the 13 long-name characters
  function automatic int ucs_off(input int i);
    int offs[13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
    return offs[i];
  endfunction

  // Update state and queue the record words for one entry
  task automatic predict_entry(input logic [255:0] ent, input logic new_dir);
    logic [7:0]  b [0:31];
    logic [7:0]  nm [0:511];
    logic [7:0]  attr;
    logic [31:0] size, clus;
    logic [15:0] ch;
    int          len, pos, n, ord, base, cnt;
    logic [63:0] chunk;
    fdp_tb_pkg::record_word_t r;
    for (int i = 0; i < 32; i++) b[i] = ent[i*8 +: 8];
    if (new_dir) begin
      for (int i = 0; i <= NAME_LIMIT; i++) name_store[i] = 8'h00;
      name_pending = 1'b0;
    end
    if (b[0] == fdp_pkg::BYTE_END) begin
      r = '{1'b1, 8'h00, 32'h0, 32'h0, 64'h0, 4'd0, 1'b1};
      expected_records.push_back(r);
      return;
    end
    if (b[0] == fdp_pkg::BYTE_DELETED) begin
      name_pending = 1'b0;
      name_store[0] = 8'h00;
      return;
    end
    attr = b[11];
    if (attr == fdp_pkg::ATTR_LONG) begin
      ord = b[0] & 8'h1F;
      if (ord < 1 || ord > fdp_pkg::ORDER_MAX) return;
      base = (ord - 1) * 13;
      cnt = 0;
      for (int i = 0; i < 13; i++) begin
        ch = {b[ucs_off(i) + 1], b[ucs_off(i)]};
        if (ch == 16'h0000 || ch == 16'hFFFF) break;
        if (base + i < NAME_LIMIT)
          name_store[base + i] = (ch >= 16'h20 && ch < 16'h7F) ? ch[7:0]
                                                               : fdp_pkg::CHAR_QMARK;
        cnt++;
      end
      if (b[0][6] && base + cnt <= NAME_LIMIT) name_store[base + cnt] = 8'h00;
      name_pending = 1'b1;
      return;
    end
    if ((attr & fdp_pkg::ATTR_VOLUME) != 8'h00) begin
      name_pending = 1'b0;
      name_store[0] = 8'h00;
      return;
    end
    size = {b[31], b[30], b[29], b[28]};
    clus = {b[21], b[20], b[27], b[26]};
    len = 0;
    if (name_pending && name_store[0] != 8'h00) begin
      while (len < NAME_LIMIT && name_store[len] != 8'h00) begin
        nm[len] = name_store[len];
        len++;
      end
    end else begin
      if (b[0] == fdp_pkg::BYTE_KANJI) b[0] = fdp_pkg::BYTE_DELETED;
      for (int i = 0; i < 8 && b[i] != fdp_pkg::CHAR_SPACE; i++) begin
        nm[len] = b[i];
        len++;
      end
      if (b[8] != fdp_pkg::CHAR_SPACE) begin
        nm[len] = fdp_pkg::CHAR_DOT;
        len++;
        for (int i = 8; i < 11 && b[i] != fdp_pkg::CHAR_SPACE; i++) begin
          nm[len] = b[i];
          len++;
        end
      end
      for (int i = 0; i < len; i++)
        if (nm[i] == 8'h00) begin
          len = i;
          break;
        end
    end
    name_pending = 1'b0;
    name_store[0] = 8'h00;
    if (len > 256) len = 256;
    pos = 0;
    do begin
      n = (len - pos > 8) ? 8 : len - pos;
      chunk = '0;
      for (int i = 0; i < n; i++) chunk[i*8 +: 8] = nm[pos + i];
      pos += n;
      r = '{1'b0, attr, size, clus, chunk, 4'(n), pos >= len};
      expected_records.push_back(r);
    end while (pos < len);
  endtask

  // Input side: predict on every accepted entry
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NAME_LIMIT; i++) name_store[i] = 8'h00;
      name_pending = 1'b0;
    end else if (in_mon.valid && in_mon.ready) begin
      predict_entry({in_mon.bytes_24_31, in_mon.bytes_16_23, in_mon.bytes_8_15,
                     in_mon.bytes_0_7}, in_mon.new_directory);
    end
  end

  // Output side: compare every accepted word
  initial fail_count = 0;
  always @(posedge clk_i) begin
    fdp_tb_pkg::record_word_t got, want;
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      got = '{out_mon.kind, out_mon.attributes, out_mon.file_size, out_mon.start_cluster,
              out_mon.name_chunk, out_mon.chunk_length, out_mon.last};
      if (expected_records.size() == 0) begin
        if (fail_count < 10) $display("unexpected word: %p", got);
        fail_count++;
      end else begin
        want = expected_records.pop_front();
        if (got != want) begin
          if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
          fail_count++;
        end
      end
    end
  end
endmodule

// ===== bench/fat_dir_entry_parser_tb.sv =====
`timescale 1ns / 100ps
// Drives directory entries with random gaps and back-pressure, gives the verdict.
module fat_dir_entry_parser_tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count;

  fdp_in_if  in_ch();
  fdp_out_if out_ch();

  fat_dir_entry_parser u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  fdp_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
                     .fail_count(fail_count), .pending_count(pending_count));

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stall per word, with calm stretches
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      repeat (gap) @(posedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      out_ch.ready <= 1'b0;
    end
  end

  // Long-name entry: order byte, 13 characters
  function automatic logic [255:0] lfn_entry(input logic [7:0] ord, input int nchars,
                                             input bit wild);
    logic [7:0]  b [0:31];
    logic [255:0] e;
    int offs[13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
    logic [15:0] c;
    for (int i = 0; i < 32; i++) b[i] = 8'($urandom);
    b[0] = ord;
    b[11] = 8'h0F;
    for (int i = 0; i < 13; i++) begin
      if (i < nchars) c = wild ? 16'($urandom) : 16'($urandom_range(16'h21, 16'h7E));
      else if (i == nchars) c = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      else c = 16'hFFFF;
      if (c == 0 && i < nchars) c = 16'h41;
      b[offs[i]] = c[7:0];
      b[offs[i] + 1] = c[15:8];
    end
    for (int i = 0; i < 32; i++) e[i*8 +: 8] = b[i];
    return e;
  endfunction

  // Regular entry with short name
  function automatic logic [255:0] reg_entry(input bit wild);
    logic [255:0] e;
    e = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < 11; i++)
      if (!wild) e[i*8 +: 8] = ($urandom_range(0, 4) == 0) ? 8'h20 : 8'($urandom_range(65, 90));
    if (e[7:0] == 8'h00 || e[7:0] == 8'hE5) e[7:0] = 8'h41;
    e[95:88] = e[95:88] & 8'hF7;
    if (e[95:88] == 8'h0F) e[95:88] = 8'h20;
    return e;
  endfunction

  task automatic send(input logic [255:0] e, input logic nd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    repeat (gap) @(posedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.bytes_0_7     <= e[63:0];
    in_ch.bytes_8_15    <= e[127:64];
    in_ch.bytes_16_23   <= e[191:128];
    in_ch.bytes_24_31   <= e[255:192];
    in_ch.new_directory <= nd;
    do @(posedge clk_i); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // A full long-name set: last chunk first, then the regular entry
  task automatic send_long_set(input int nparts, input bit wild);
    int tail;
    tail = $urandom_range(1, 13);
    for (int p = nparts; p >= 1; p--)
      send(lfn_entry(8'(p) | ((p == nparts) ? 8'h40 : 8'h00), (p == nparts) ? tail : 13,
                     wild), 1'b0);
    send(reg_entry(1'b0), 1'b0);
  endtask

  initial begin
    logic [255:0] e;
    in_ch.valid = 1'b0;
    in_ch.bytes_0_7 = '0;
    in_ch.bytes_8_15 = '0;
    in_ch.bytes_16_23 = '0;
    in_ch.bytes_24_31 = '0;
    in_ch.new_directory = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end marker, all-ones, deleted, volume, kanji, no ext, empty name
    send('0, 1'b1);
    send({256{1'b1}}, 1'b0);
    e = reg_entry(1'b0); e[7:0] = 8'hE5; send(e, 1'b0);
    e = reg_entry(1'b0); e[95:88] = 8'h08; send(e, 1'b0);
    e = reg_entry(1'b0); e[7:0] = 8'h05; send(e, 1'b0);
    e = reg_entry(1'b0); e[71:64] = 8'h20; send(e, 1'b0);
    e = reg_entry(1'b0); e[7:0] = 8'h20; e[71:64] = 8'h20; send(e, 1'b0);
    e = reg_entry(1'b1); e[23:16] = 8'h00; send(e, 1'b0);
    // Out-of-range orders, wild characters, longest name, store bound
    send(lfn_entry(8'h40, 5, 1'b0), 1'b0);
    send(lfn_entry(8'h55, 5, 1'b0), 1'b0);
    send(reg_entry(1'b0), 1'b0);
    send_long_set(2, 1'b1);
    for (int p = 20; p >= 1; p--) send(lfn_entry(8'(p), 13, 1'b0), 1'b0);
    send(reg_entry(1'b0), 1'b0);
    send(lfn_entry(8'h14, 13, 1'b0), 1'b1);
    send(reg_entry(1'b0), 1'b0);
    // Pending name dropped by deleted entry
    send(lfn_entry(8'h41, 4, 1'b0), 1'b0);
    e = reg_entry(1'b0); e[7:0] = 8'hE5; send(e, 1'b0);
    send(reg_entry(1'b0), 1'b0);

    // Random: mostly well-formed long-name sets, some noise
    for (int n = 0; n < 160; n++) begin
      case ($urandom_range(0, 5))
        0, 1: send_long_set(int'($urandom_range(1, 3)), $urandom_range(0, 3) == 0);
        2: send(reg_entry(1'($urandom_range(0, 1))), $urandom_range(0, 7) == 0);
        3: send(lfn_entry(8'($urandom), int'($urandom_range(0, 13)),
                          1'($urandom_range(0, 1))),
                $urandom_range(0, 7) == 0);
        4: send({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom}, 1'($urandom_range(0, 1)));
        default: begin
          if ($urandom_range(0, 9) == 0) send_long_set(int'($urandom_range(15, 20)), 1'b0);
          else send('0, 1'b0);
        end
      endcase
    end

    // Let the checker see the last accepted entry before draining
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
